// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/cda_pkg.sv -----
// Shared types, constants and helper functions for the calendar date adder.
// No dependencies; used by cda_ctrl, cda_dp and the top level.
package cda_pkg;

  localparam int MODE_W   = 2;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFFSET_W = 17;
  localparam int REM_W    = 9;   // year modulo 400
  localparam int WIDE_W   = 18;  // working width for years, day counts and month spans
  localparam int PROD_W   = 2 * WIDE_W;

  // Reciprocal of 12: exact floor for operands below 2^19.
  localparam logic [WIDE_W-1:0] RECIP12       = 18'd174763;
  localparam int                RECIP12_SHIFT = 21;
  localparam int                Q12_W         = 14;
  // Month bias keeps the month count non-negative before the divide.
  localparam logic [WIDE_W-1:0] MONTH_BIAS    = 18'd5462;
  localparam logic [WIDE_W-1:0] MONTH_SPAN    = 18'd65544;  // 12 * MONTH_BIAS

  // Reciprocal of 400: exact floor for operands below 43690.
  localparam logic [WIDE_W-1:0] RECIP400       = 18'd10486;
  localparam int                RECIP400_SHIFT = 22;
  localparam int                Q400_W         = 6;
  localparam logic [WIDE_W-1:0] YEAR_BIAS      = 18'd400;

  localparam logic [WIDE_W-1:0] DAYS_PER_YEAR = 18'd365;
  localparam int                YEAR_MIN      = 1;
  localparam int                YEAR_MAX      = 9999;

  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_DAYS   = 2'd0,
    MODE_MONTHS = 2'd1,
    MODE_YEARS  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_MONTH,
    OP_APPLY_MONTH,
    OP_CHECK,
    OP_MUL_YEAR,
    OP_SET_REM,
    OP_WALK,
    OP_END_WALK,
    OP_CLAMP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  year_bad;
    logic  walk_done;
  } dp_status_t;

  // Leap year test on the year taken modulo 400.
  function automatic logic is_leap(input logic [REM_W-1:0] r);
    is_leap = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [REM_W-1:0] rem_inc(input logic [REM_W-1:0] r);
    rem_inc = (r == 9'd399) ? 9'd0 : r + 9'd1;
  endfunction

  function automatic logic [REM_W-1:0] rem_dec(input logic [REM_W-1:0] r);
    rem_dec = (r == 9'd0) ? 9'd399 : r - 9'd1;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - 4'd1;
    if (m == FEBRUARY) begin
      month_days = leap ? 5'd29 : 5'd28;
    end else if (idx < 4'd12) begin
      month_days = MONTH_LEN[idx];
    end else begin
      month_days = 5'd31;
    end
  endfunction

endpackage

// ----- hw/rtl/cda_ctrl.sv -----
// Sequencing state machine of the calendar date adder.
// Depends on cda_pkg; drives cda_dp through dp_cmd_t and reads dp_status_t.
module cda_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cda_pkg::dp_status_t  status,
  output cda_pkg::dp_cmd_t     cmd
);
  import cda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MDIV,
    S_MAPPLY,
    S_CHECK,
    S_YMUL,
    S_YMOD,
    S_WALK,
    S_CLAMP,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.mode)
          MODE_NONE:   state_next = S_FINISH;
          MODE_MONTHS: state_next = S_MDIV;
          MODE_DAYS,
          MODE_YEARS:  state_next = S_CHECK;
          default:     state_next = S_CHECK;
        endcase
      end
      S_MDIV: begin
        cmd.op     = OP_MUL_MONTH;
        state_next = S_MAPPLY;
      end
      S_MAPPLY: begin
        cmd.op     = OP_APPLY_MONTH;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op = OP_CHECK;
        if (status.mode != MODE_DAYS && status.year_bad) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_YMUL;
        end
      end
      S_YMUL: begin
        cmd.op     = OP_MUL_YEAR;
        state_next = S_YMOD;
      end
      S_YMOD: begin
        cmd.op     = OP_SET_REM;
        state_next = (status.mode == MODE_DAYS) ? S_WALK : S_CLAMP;
      end
      S_WALK: begin
        if (status.walk_done) begin
          cmd.op     = OP_END_WALK;
          state_next = S_FINISH;
        end else begin
          cmd.op = OP_WALK;
        end
      end
      S_CLAMP: begin
        cmd.op     = OP_CLAMP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (fire) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/cda_dp.sv -----
// Datapath of the calendar date adder: date registers, shared reciprocal
// multiplier, year/month walker and result register. Depends on cda_pkg.
module cda_dp (
  input  logic                                clk,
  input  cda_pkg::dp_cmd_t                    cmd,
  output cda_pkg::dp_status_t                 status,
  input  logic [cda_pkg::MODE_W-1:0]          mode,
  input  logic [cda_pkg::YEAR_W-1:0]          start_year,
  input  logic [cda_pkg::MONTH_W-1:0]         start_month,
  input  logic [cda_pkg::DAY_W-1:0]           start_day,
  input  logic signed [cda_pkg::OFFSET_W-1:0] offset,
  output logic [cda_pkg::YEAR_W-1:0]          result_year,
  output logic [cda_pkg::MONTH_W-1:0]         result_month,
  output logic [cda_pkg::DAY_W-1:0]           result_day,
  output logic                                range_error
);
  import cda_pkg::*;

  // Request registers.
  mode_t                       mode_q;
  logic [YEAR_W-1:0]           sy_q;
  logic [MONTH_W-1:0]          sm_q;
  logic [DAY_W-1:0]            sd_q;
  logic signed [OFFSET_W-1:0]  off_q;

  // Working registers. cnt holds the day count from the first of the month
  // during the day walk and the day of month otherwise.
  logic signed [WIDE_W-1:0]    yr;
  logic [MONTH_W-1:0]          mon;
  logic signed [WIDE_W-1:0]    cnt;
  logic [REM_W-1:0]            rem;
  logic                        err;
  logic [PROD_W-1:0]           prod;

  // Input normalization.
  logic signed [WIDE_W-1:0]    sy_ext;
  logic signed [WIDE_W-1:0]    sd_ext;
  logic signed [WIDE_W-1:0]    off_in_ext;
  logic signed [WIDE_W-1:0]    norm_y;
  logic [MONTH_W-1:0]          norm_m;

  // Multiplier and division results.
  logic [WIDE_W-1:0]           month_t;
  logic [WIDE_W-1:0]           yb;
  logic [WIDE_W-1:0]           mul_a;
  logic [WIDE_W-1:0]           mul_b;
  logic [Q12_W-1:0]            q12;
  logic [Q400_W-1:0]           q400;
  logic [WIDE_W-1:0]           month_rem;

  // Walker.
  logic                        leap_cur;
  logic                        leap_next;
  logic                        leap_prev;
  logic                        early;
  logic signed [WIDE_W-1:0]    ylen_back;
  logic signed [WIDE_W-1:0]    ylen_fwd;
  logic [DAY_W-1:0]            mlen;
  logic signed [WIDE_W-1:0]    mlen_ext;
  logic                        cnt_neg;
  logic                        go_year;
  logic                        go_month;
  logic                        year_bad;
  logic [DAY_W-1:0]            clamp_day;

  assign sy_ext     = signed'(WIDE_W'(start_year));
  assign sd_ext     = signed'(WIDE_W'(start_day));
  assign off_in_ext = WIDE_W'(offset);

  always_comb begin
    if (start_month == 4'd0) begin
      norm_y = sy_ext - 18'sd1;
      norm_m = DECEMBER;
    end else if (start_month > DECEMBER) begin
      norm_y = sy_ext + 18'sd1;
      norm_m = start_month - DECEMBER;
    end else begin
      norm_y = sy_ext;
      norm_m = start_month;
    end
  end

  // Biased month count; its true value always fits the unsigned width.
  assign month_t = WIDE_W'(mon) - 18'd1 + WIDE_W'(off_q) + MONTH_SPAN;
  assign yb      = WIDE_W'(yr) + YEAR_BIAS;

  assign mul_a = (cmd.op == OP_MUL_MONTH) ? month_t : yb;
  assign mul_b = (cmd.op == OP_MUL_MONTH) ? RECIP12 : RECIP400;

  assign q12       = prod[RECIP12_SHIFT +: Q12_W];
  assign q400      = prod[RECIP400_SHIFT +: Q400_W];
  assign month_rem = month_t - ((WIDE_W'(q12) << 3) + (WIDE_W'(q12) << 2));

  assign year_bad = (yr < 18'sd1) || (yr > 18'sd9999);

  assign leap_cur  = is_leap(rem);
  assign leap_next = is_leap(rem_inc(rem));
  assign leap_prev = is_leap(rem_dec(rem));
  assign early     = (mon <= FEBRUARY);

  // The twelve months ahead of the current month hold the February of the current year
  // when the month is January or February; the twelve behind it hold it otherwise.
  assign ylen_back = signed'(DAYS_PER_YEAR + WIDE_W'(early ? leap_prev : leap_cur));
  assign ylen_fwd  = signed'(DAYS_PER_YEAR + WIDE_W'(early ? leap_cur : leap_next));
  assign mlen      = month_days(mon, leap_cur);
  assign mlen_ext  = signed'(WIDE_W'(mlen));

  assign cnt_neg  = (cnt < 18'sd0);
  assign go_year  = !cnt_neg && (cnt >= ylen_fwd);
  assign go_month = !cnt_neg && !go_year && (cnt >= mlen_ext);

  always_comb begin
    clamp_day = cnt[DAY_W-1:0];
    if (clamp_day > mlen) begin
      clamp_day = mlen;
    end
    if (clamp_day == 5'd0) begin
      clamp_day = 5'd1;
    end
  end

  assign status.mode      = mode_q;
  assign status.year_bad  = year_bad;
  assign status.walk_done = !cnt_neg && !go_year && !go_month;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_IDLE: begin
      end
      OP_LOAD: begin
        mode_q <= mode_t'(mode);
        sy_q   <= start_year;
        sm_q   <= start_month;
        sd_q   <= start_day;
        off_q  <= offset;
        err    <= 1'b0;
        unique case (mode_t'(mode))
          MODE_NONE: begin
            yr  <= sy_ext;
            mon <= start_month;
            cnt <= sd_ext;
          end
          MODE_DAYS: begin
            yr  <= norm_y;
            mon <= norm_m;
            cnt <= sd_ext - 18'sd1 + off_in_ext;
          end
          MODE_MONTHS: begin
            yr  <= norm_y;
            mon <= norm_m;
            cnt <= sd_ext;
          end
          MODE_YEARS: begin
            yr  <= norm_y + off_in_ext;
            mon <= norm_m;
            cnt <= sd_ext;
          end
          default: begin
            yr  <= sy_ext;
            mon <= start_month;
            cnt <= sd_ext;
          end
        endcase
      end
      OP_MUL_MONTH, OP_MUL_YEAR: begin
        prod <= mul_a * mul_b;
      end
      OP_APPLY_MONTH: begin
        yr  <= yr + signed'(WIDE_W'(q12)) - signed'(MONTH_BIAS);
        mon <= month_rem[MONTH_W-1:0] + JANUARY;
      end
      OP_CHECK: begin
        err <= (mode_q != MODE_DAYS) && year_bad;
      end
      OP_SET_REM: begin
        rem <= REM_W'(yb - WIDE_W'(q400) * YEAR_BIAS);
      end
      OP_WALK: begin
        priority if (cnt_neg) begin
          cnt <= cnt + ylen_back;
          yr  <= yr - 18'sd1;
          rem <= rem_dec(rem);
        end else if (go_year) begin
          cnt <= cnt - ylen_fwd;
          yr  <= yr + 18'sd1;
          rem <= rem_inc(rem);
        end else if (go_month) begin
          cnt <= cnt - mlen_ext;
          if (mon == DECEMBER) begin
            mon <= JANUARY;
            yr  <= yr + 18'sd1;
            rem <= rem_inc(rem);
          end else begin
            mon <= mon + 4'd1;
          end
        end
      end
      OP_END_WALK: begin
        err <= year_bad;
        cnt <= cnt + 18'sd1;
      end
      OP_CLAMP: begin
        cnt <= signed'(WIDE_W'(clamp_day));
      end
      OP_OUT: begin
        range_error <= err;
        if (err) begin
          result_year  <= sy_q;
          result_month <= sm_q;
          result_day   <= sd_q;
        end else begin
          result_year  <= yr[YEAR_W-1:0];
          result_month <= mon;
          result_day   <= cnt[DAY_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/calendar_date_add.sv -----
// Top level of the calendar date adder: joins the controller and datapath.
// Depends on cda_pkg, cda_ctrl and cda_dp.
//
// Usage: one request on the input channel (in_valid/in_ready) carries a start
// date, a signed offset and a mode (add days, months, years or nothing). The
// block answers each request with exactly one result on the output channel
// (out_valid/out_ready): the new date and a range_error flag that is set, with
// the start date handed back, when the result year of an add leaves 1..9999.
// Requests are worked one at a time; in_ready is high only while idle.
// Month and year requests whose result year leaves range skip the year divide
// and the clamp. The day walker takes one whole year or one month per cycle.
// Results sit in an output register: while the receiver stalls, the next
// request can be accepted and worked, and the block waits only when it has
// a second result ready. Synchronous reset clears the controller and drops
// out_valid; the datapath registers need no reset.
module calendar_date_add (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cda_pkg::MODE_W-1:0]          mode,
  input  logic [cda_pkg::YEAR_W-1:0]          start_year,
  input  logic [cda_pkg::MONTH_W-1:0]         start_month,
  input  logic [cda_pkg::DAY_W-1:0]           start_day,
  input  logic signed [cda_pkg::OFFSET_W-1:0] offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cda_pkg::YEAR_W-1:0]          result_year,
  output logic [cda_pkg::MONTH_W-1:0]         result_month,
  output logic [cda_pkg::DAY_W-1:0]           result_day,
  output logic                                range_error
);
  import cda_pkg::*;

  // Command from the controller and status back from the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences normalization, the reciprocal divides, the
  // year/month walk and the hand-off into the output register.
  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath captures the request on the load command and holds the
  // result register that drives the output fields.
  cda_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .mode         (mode),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .offset       (offset),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .range_error  (range_error)
  );

endmodule

// ----- hw/rtl/cda_checker.sv -----
// Port-level checker for the calendar date adder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cda_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  mode,
  input logic [13:0] start_year,
  input logic [3:0]  start_month,
  input logic [4:0]  start_day,
  input logic [16:0] offset,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] result_year,
  input logic [3:0]  result_month,
  input logic [4:0]  result_day,
  input logic        range_error
);

  // A stalled result keeps its value.
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({result_year, result_month, result_day, range_error}))

  // Requests are worked one at a time.
  `ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // A new result only comes out of a request in progress, and the block is
  // idle again once it is published.
  `ASSERT_IMP(a_rise_from_busy, clk, rst, $rose(out_valid), $past(!in_ready))
  `ASSERT_IMP(a_idle_after_rise, clk, rst, $rose(out_valid), in_ready)

endmodule

bind calendar_date_add cda_checker u_cda_checker (.*);

// ----- dv/calendar_date_add_test.sv -----
// Self-checking testbench for calendar_date_add: day, month and year offsets on Gregorian dates.
// Depends on cda_pkg for the mode codes and field widths; drives the block with no other files.
`timescale 1ns / 100ps

module calendar_date_add_test;
  import cda_pkg::*;

  // Run sizing. Day requests walk the longest and each side may idle before every request,
  // so the cycle limit sits well above the slowest correct run.
  localparam int RANDOM_ITEMS = 780;
  localparam int DRAIN_AT     = 390;
  localparam int TAIL_CYCLES  = 250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int NUM_ROWS     = 26;
  localparam longint YEAR_SHIFT   = 400;
  localparam longint DAYS_PER_ERA = 146097;

  typedef struct packed {
    mode_t                       mode;
    logic [YEAR_W-1:0]           year;
    logic [MONTH_W-1:0]          month;
    logic [DAY_W-1:0]            day;
    logic signed [OFFSET_W-1:0]  offset;
  } date_request_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               range_error;
  } date_result_t;

  // One directed row: the request, and the expected result where it is typed in.
  typedef struct packed {
    date_request_t req;
    logic          typed;
    date_result_t  want;
  } date_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] mode = '0;
  logic [YEAR_W-1:0] start_year = '0;
  logic [MONTH_W-1:0] start_month = '0;
  logic [DAY_W-1:0] start_day = '0;
  logic signed [OFFSET_W-1:0] offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [YEAR_W-1:0] result_year;
  logic [MONTH_W-1:0] result_month;
  logic [DAY_W-1:0] result_day;
  logic range_error;

  date_result_t pending_dates[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int result_count = 0;

  calendar_date_add DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .start_year(start_year),
    .start_month(start_month),
    .start_day(start_day),
    .offset(offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_year(result_year),
    .result_month(result_month),
    .result_day(result_day),
    .range_error(range_error)
  );

  always #4 clk = ~clk;

  // Directed rows. Typed expectations cover the obvious cases: the unused mode, results
  // that equal the start, and range errors that hand the start date back. Every other
  // row goes through the date predictor.
  localparam date_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{MODE_NONE,   14'd2024,  4'd2,  5'd29, 17'sd12345}, 1'b1, '{14'd2024, 4'd2, 5'd29, 1'b0}},
    '{'{MODE_NONE,   14'd16383, 4'd15, 5'd31, 17'h1FFFF},  1'b1, '{14'd16383, 4'd15, 5'd31, 1'b0}},
    '{'{MODE_DAYS,   14'd1,     4'd1,  5'd1,  17'sd0},     1'b1, '{14'd1, 4'd1, 5'd1, 1'b0}},
    '{'{MODE_DAYS,   14'd9999,  4'd12, 5'd31, 17'sd0},     1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
    '{'{MODE_DAYS,   14'd9999,  4'd12, 5'd31, 17'sd1},     1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
    '{'{MODE_DAYS,   14'd1,     4'd1,  5'd1,  -17'sd1},    1'b1, '{14'd1, 4'd1, 5'd1, 1'b1}},
    '{'{MODE_DAYS,   14'd2000,  4'd2,  5'd28, 17'sd1},     1'b0, '0},
    '{'{MODE_DAYS,   14'd1900,  4'd2,  5'd28, 17'sd1},     1'b0, '0},
    '{'{MODE_DAYS,   14'd2024,  4'd3,  5'd1,  -17'sd1},    1'b0, '0},
    '{'{MODE_DAYS,   14'd5000,  4'd6,  5'd15, 17'h0FFFF},  1'b0, '0},
    '{'{MODE_DAYS,   14'd5000,  4'd6,  5'd15, 17'h10000},  1'b0, '0},
    '{'{MODE_DAYS,   14'd2024,  4'd3,  5'd0,  17'sd0},     1'b0, '0},
    '{'{MODE_DAYS,   14'd2023,  4'd2,  5'd31, 17'sd0},     1'b0, '0},
    '{'{MODE_MONTHS, 14'd2024,  4'd1,  5'd31, 17'sd1},     1'b0, '0},
    '{'{MODE_MONTHS, 14'd2023,  4'd1,  5'd31, 17'sd1},     1'b0, '0},
    '{'{MODE_MONTHS, 14'd2024,  4'd3,  5'd31, -17'sd13},   1'b0, '0},
    '{'{MODE_MONTHS, 14'd2024,  4'd0,  5'd0,  17'sd0},     1'b0, '0},
    '{'{MODE_MONTHS, 14'd2024,  4'd15, 5'd31, 17'sd0},     1'b0, '0},
    '{'{MODE_MONTHS, 14'd1,     4'd1,  5'd1,  -17'sd1},    1'b1, '{14'd1, 4'd1, 5'd1, 1'b1}},
    '{'{MODE_MONTHS, 14'd9999,  4'd12, 5'd1,  17'sd1},     1'b1, '{14'd9999, 4'd12, 5'd1, 1'b1}},
    '{'{MODE_MONTHS, 14'd16383, 4'd1,  5'd1,  17'sd0},     1'b1, '{14'd16383, 4'd1, 5'd1, 1'b1}},
    '{'{MODE_YEARS,  14'd2024,  4'd2,  5'd29, 17'sd1},     1'b0, '0},
    '{'{MODE_YEARS,  14'd2024,  4'd2,  5'd29, 17'sd4},     1'b0, '0},
    '{'{MODE_YEARS,  14'd5000,  4'd1,  5'd1,  17'h0FFFF},  1'b1, '{14'd5000, 4'd1, 5'd1, 1'b1}},
    '{'{MODE_YEARS,  14'd0,     4'd6,  5'd10, 17'sd1},     1'b0, '0},
    '{'{MODE_YEARS,  14'd5000,  4'd1,  5'd1,  17'h10000},  1'b1, '{14'd5000, 4'd1, 5'd1, 1'b1}}
  };

  // ---------------------------------------------------------------------------------------
  // Date predictor. Years are shifted by 400 for the day count so that every count stays
  // non-negative; the era arithmetic below then works with truncating division.
  // ---------------------------------------------------------------------------------------
  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint days_in_month(longint y, longint m);
    longint lens [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (m == 2) return leap ? 29 : 28;
    return lens[m - 1];
  endfunction

  // Day number counted from 1 March of year 0 of the shifted calendar.
  function automatic longint day_number(longint y, longint m, longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy  = y - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? (m - 3) : (m + 9);
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * DAYS_PER_ERA + doe;
  endfunction

  function automatic void date_of_number(longint z, output longint y, output longint m,
                                         output longint d);
    longint era, doe, yoe, doy, mp;
    era = z / DAYS_PER_ERA;
    doe = z - era * DAYS_PER_ERA;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    m   = (mp < 10) ? (mp + 3) : (mp - 9);
    d   = doy - (153 * mp + 2) / 5 + 1;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  function automatic date_result_t predict_date(date_request_t r);
    longint off, lin, y, m, d, z, step, lim;
    bit bad;
    date_result_t res;
    off = longint'(r.offset[OFFSET_W-2:0]) - (r.offset[OFFSET_W-1] ? 65536 : 0);
    // Out-of-range months carry into the year as a plain month count, in every adding mode.
    lin = longint'(r.year) * 12 + longint'(r.month) - 1;
    y   = floor_div(lin, 12);
    m   = lin - y * 12 + 1;
    d   = longint'(r.day);
    bad = 1'b0;
    if (r.mode == MODE_NONE) begin
      res = '{r.year, r.month, r.day, 1'b0};
      return res;
    end
    if (r.mode == MODE_DAYS) begin
      // A day of zero or past the month end simply counts from the month start.
      z = day_number(y + YEAR_SHIFT, m, d) + off;
      date_of_number(z, y, m, d);
      y -= YEAR_SHIFT;
      bad = (y < 1 || y > 9999);
    end else begin
      // Year mode is month mode with twelve months per year.
      step = (r.mode == MODE_MONTHS) ? off : off * 12;
      lin  = y * 12 + (m - 1) + step;
      y    = floor_div(lin, 12);
      m    = lin - y * 12 + 1;
      if (y < 1 || y > 9999) begin
        bad = 1'b1;
      end else begin
        lim = days_in_month(y, m);
        if (d > lim) d = lim;
        if (d < 1) d = 1;
      end
    end
    // A range error hands the start fields back as received.
    if (bad) res = '{r.year, r.month, r.day, 1'b1};
    else res = '{y[YEAR_W-1:0], m[MONTH_W-1:0], d[DAY_W-1:0], 1'b0};
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------

  // The last twenty of every hundred requests or results run with no idling at all.
  function automatic int idle_cycles(int n);
    if ((n % 100) >= 80) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Mostly valid dates with offsets of several sizes; some requests are pure noise over
  // the full width of every field, which also reaches the unused mode and odd months.
  function automatic date_request_t random_request();
    date_request_t r;
    int v;
    if ($urandom_range(0, 99) < 12) begin
      r.mode   = mode_t'($urandom_range(0, 3));
      r.year   = YEAR_W'($urandom);
      r.month  = MONTH_W'($urandom);
      r.day    = DAY_W'($urandom);
      r.offset = OFFSET_W'($urandom);
      return r;
    end
    r.mode = ($urandom_range(0, 99) < 4) ? MODE_NONE : mode_t'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0: r.year = YEAR_W'($urandom_range(1, 3));
      1: r.year = YEAR_W'($urandom_range(9997, 9999));
      default: r.year = YEAR_W'($urandom_range(1, 9999));
    endcase
    r.month = MONTH_W'($urandom_range(1, 12));
    r.day   = DAY_W'($urandom_range(1,
                int'(days_in_month(longint'(r.year), longint'(r.month)))));
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 80)) - 40;
      1: v = int'($urandom_range(0, 2000)) - 1000;
      2: v = int'($urandom_range(0, 24000)) - 12000;
      default: v = $urandom;
    endcase
    r.offset = v[OFFSET_W-1:0];
    return r;
  endfunction

  // Presents one request and waits for it to be taken. Valid is only lowered when a gap
  // or a drain is really coming, so it is never lowered and raised in the same step.
  task automatic drive_request(date_request_t r, logic typed, date_result_t want,
                               bit drain);
    int gap;
    gap = idle_cycles(sent_count);
    if (gap > 0 || (drain && pending_dates.size() != 0)) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && pending_dates.size() != 0) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= r.mode;
    start_year  <= r.year;
    start_month <= r.month;
    start_day   <= r.day;
    offset      <= r.offset;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(typed ? want : predict_date(r));
    sent_count++;
  endtask

  task automatic check_result();
    date_result_t want;
    if (pending_dates.size() == 0) begin
      $error("result arrived with no request outstanding");
      mismatch_count++;
    end else begin
      want = pending_dates.pop_front();
      if (result_year !== want.year) begin
        $error("result_year expected %0d actual %0d", want.year, result_year);
        mismatch_count++;
      end
      if (result_month !== want.month) begin
        $error("result_month expected %0d actual %0d", want.month, result_month);
        mismatch_count++;
      end
      if (result_day !== want.day) begin
        $error("result_day expected %0d actual %0d", want.day, result_day);
        mismatch_count++;
      end
      if (range_error !== want.range_error) begin
        $error("range_error expected %0d actual %0d", want.range_error, range_error);
        mismatch_count++;
      end
    end
    result_count++;
  endtask

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("calendar_date_add_test failed");
      $finish;
    end
  end

  // Receiver: stalls for a random count before each result, then takes and checks it.
  initial begin : receive_results
    int stall;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = idle_cycles(result_count);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result();
    end
  end

  // Sender: reset, the directed table, then the random requests with one full drain of
  // the block partway through, and finally the wait for the last results.
  initial begin : send_requests
    date_row_t row;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      drive_request(row.req, row.typed, row.want, 1'b0);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      drive_request(random_request(), 1'b0, '0, i == DRAIN_AT);
    end
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    // Any stray result after the last expected one still gets flagged by the receiver.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_dates.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("calendar_date_add_test passed");
    end else begin
      $display("calendar_date_add_test failed");
    end
    $finish;
  end

endmodule
